// ===== rtl/compacting_value_list_engine_assert.svh =====
// assertion macros for the rtl, checked against clock and reset of the module
`ifndef COMPACTING_VALUE_LIST_ENGINE_ASSERT_SVH
`define COMPACTING_VALUE_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define CVLE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define CVLE_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CVLE_ASSERT_IMP(lbl, ante, cons, msg)
`define CVLE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/cvle_pkg.sv =====
package cvle_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   // walk pointer runs one past the fill count
   localparam int PTR_W      = $clog2(DEPTH + 2);

   typedef logic [DATA_WIDTH-1:0] word_type;

   localparam logic [2:0] ACT_PUSH   = 3'd0;
   localparam logic [2:0] ACT_ADD    = 3'd1;
   localparam logic [2:0] ACT_GET    = 3'd2;
   localparam logic [2:0] ACT_FIND   = 3'd3;
   localparam logic [2:0] ACT_REMOVE = 3'd4;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] operand;
      logic [5:0]         position;
   } cvle_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] read_value;
      logic [5:0]         found_index;
      logic [6:0]         entry_count;
   } cvle_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_GET_WAIT,
      S_ADD,
      S_SCAN,
      S_SHIFT
   } cvle_state_type;

endpackage

// ===== rtl/cvle_ram.sv =====
module cvle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cvle_alu.sv =====
module cvle_alu import cvle_pkg::*; (
   input  word_type a,
   input  word_type b,
   output word_type sum,
   output logic     equal
);

   // wraps modulo 2^DATA_WIDTH
   assign sum   = a + b;
   assign equal = (a == b);

endmodule

// ===== rtl/compacting_value_list_engine.sv =====
// Ordered list of up to DEPTH signed words with a fill count.
// Request channel: start, busy, req_item (action, operand, position). An item is
// taken at a rising edge with start high and busy low; busy then stays high
// until the result is registered.
// Result channel: rsp_strobe, rsp_item (status, read_value, found_index,
// entry_count). Each item gives one result, shown for exactly one cycle; the
// receiver cannot hold it off, and the next item may be taken in that cycle.
// Push, get and unused actions do not walk the list; add walks every entry,
// find walks up to a match or the end, and remove then moves the later
// entries down one place. The entries sit in a single-port-write,
// registered-read RAM that is walked one entry per cycle through one shared
// adder and comparator.
// Reset (synchronous, active high) empties the list and drops busy; the RAM
// needs no clearing since only entries below the fill count are ever read.
`include "compacting_value_list_engine_assert.svh"

module compacting_value_list_engine import cvle_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  cvle_req_type req_item,
   output logic         rsp_strobe,
   output cvle_rsp_type rsp_item
);

   cvle_state_type   state_ff, state_in;
   cvle_req_type     req_ff, req_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   cvle_rsp_type     rsp_ff, rsp_in;

   logic             mem_we;
   logic [IDX_W-1:0] mem_wr_addr;
   word_type         mem_wr_data;
   logic [IDX_W-1:0] mem_rd_addr;
   word_type         mem_rd_data;

   word_type         op_ext;
   word_type         alu_sum;
   logic             alu_equal;
   logic [PTR_W-1:0] count_ptr;
   logic             get_in_range;

   assign op_ext       = DATA_WIDTH'(req_ff.operand);
   assign count_ptr    = PTR_W'(count_ff);
   assign get_in_range = 32'(req_ff.position) < 32'(count_ff);

   cvle_ram #(
      .WIDTH(DATA_WIDTH),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .we     (mem_we),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   cvle_alu u_alu (
      .a    (mem_rd_data),
      .b    (op_ext),
      .sum  (alu_sum),
      .equal(alu_equal)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ptr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_wr_addr  = '0;
      mem_wr_data  = alu_sum;
      mem_rd_addr  = IDX_W'(ptr_ff);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               ptr_in   = '0;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            rsp_in.status      = STATUS_OK;
            rsp_in.read_value  = '0;
            rsp_in.found_index = '0;
            rsp_in.entry_count = 7'(count_ff);
            case (req_ff.action)
               ACT_PUSH: begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
                  if (32'(count_ff) >= DEPTH) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     mem_we             = 1'b1;
                     mem_wr_addr        = IDX_W'(count_ff);
                     mem_wr_data        = op_ext;
                     count_in           = count_ff + 1'b1;
                     rsp_in.entry_count = 7'(count_in);
                  end
               end
               ACT_GET: begin
                  if (get_in_range) begin
                     mem_rd_addr = IDX_W'(req_ff.position);
                     state_in    = S_GET_WAIT;
                  end else begin
                     rsp_in.status = STATUS_MISS;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               ACT_ADD: begin
                  state_in = S_ADD;
               end
               ACT_FIND, ACT_REMOVE: begin
                  state_in = S_SCAN;
               end
               default: begin
                  rsp_in.status = STATUS_MISS;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end
            endcase
         end

         S_GET_WAIT: begin
            rsp_in.read_value = 32'(mem_rd_data);
            rsp_valid_in      = 1'b1;
            state_in          = S_IDLE;
         end

         // read entry ptr while writing back entry ptr-1 plus the increment
         S_ADD: begin
            if (ptr_ff != '0) begin
               mem_we      = 1'b1;
               mem_wr_addr = IDX_W'(ptr_ff - 1'b1);
               mem_wr_data = alu_sum;
            end
            if (ptr_ff == count_ptr) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         // read data holds entry ptr-1
         S_SCAN: begin
            if (ptr_ff != '0 && alu_equal) begin
               if (req_ff.action == ACT_REMOVE) begin
                  ptr_in   = ptr_ff + 1'b1;
                  state_in = S_SHIFT;
               end else begin
                  rsp_in.found_index = 6'(ptr_ff - 1'b1);
                  rsp_valid_in       = 1'b1;
                  state_in           = S_IDLE;
               end
            end else if (ptr_ff == count_ptr) begin
               rsp_in.status = STATUS_MISS;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         // move entry ptr-1 down to ptr-2
         S_SHIFT: begin
            if (ptr_ff <= count_ptr) begin
               mem_we      = 1'b1;
               mem_wr_addr = IDX_W'(ptr_ff - 2'd2);
               mem_wr_data = mem_rd_data;
            end
            if (ptr_ff >= count_ptr) begin
               count_in           = count_ff - 1'b1;
               rsp_in.entry_count = 7'(count_in);
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   `CVLE_ASSERT_IMP(a_count_bound, 1'b1, 32'(count_ff) <= DEPTH, "fill count above depth")
   `CVLE_ASSERT_IMP(a_no_write_idle, state_ff == S_IDLE, !mem_we, "ram write while idle")
   `CVLE_ASSERT_NXT(a_strobe_gap, rsp_valid_ff, !rsp_valid_ff, "back to back results")
   `CVLE_ASSERT_NXT(a_accept_decode, start && !busy, state_ff == S_DECODE, "item not decoded")

endmodule

// ===== verif/cvle_list_checker.sv =====
module cvle_list_checker import cvle_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  cvle_req_type req_item,
   input  logic         rsp_strobe,
   input  cvle_rsp_type rsp_item,
   output int           err_count,
   output int           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   word_type     list_words [DEPTH];
   int           fill_level;
   cvle_rsp_type rsp_due_q [$];

   // applies one item to the shadow list and returns the result it must give
   function automatic cvle_rsp_type apply_list_op(input cvle_req_type r);
      cvle_rsp_type o;
      int           hit;
      o = '0;
      o.status = STATUS_OK;
      hit = -1;
      if (r.action == ACT_FIND || r.action == ACT_REMOVE) begin
         for (int i = 0; i < fill_level; i++) begin
            if (hit < 0 && list_words[i] == word_type'(r.operand)) hit = i;
         end
      end
      case (r.action)
         ACT_PUSH: begin
            if (fill_level >= DEPTH) begin
               o.status = STATUS_FULL;
            end else begin
               list_words[fill_level] = r.operand;
               fill_level++;
            end
         end
         ACT_ADD: begin
            for (int i = 0; i < fill_level; i++) list_words[i] = list_words[i] + r.operand;
         end
         ACT_GET: begin
            if (int'(r.position) < fill_level) o.read_value = list_words[r.position];
            else o.status = STATUS_MISS;
         end
         ACT_FIND: begin
            if (hit < 0) o.status = STATUS_MISS;
            else o.found_index = IDX_W'(hit);
         end
         ACT_REMOVE: begin
            if (hit < 0) begin
               o.status = STATUS_MISS;
            end else begin
               // close the gap left by the removed entry
               for (int i = hit; i < fill_level - 1; i++) list_words[i] = list_words[i + 1];
               fill_level--;
            end
         end
         default: o.status = STATUS_MISS;
      endcase
      o.entry_count = CNT_W'(fill_level);
      return o;
   endfunction

   task automatic compare_field(input string fname, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", fname, want, got);
         err_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      cvle_rsp_type want;
      if (reset) begin
         rsp_due_q.delete();
         fill_level = 0;
      end else begin
         // a result and a new item can meet on one edge: the result is the older one
         if (rsp_strobe === 1'b1) begin
            if (rsp_due_q.size() == 0) begin
               $error("result with no item outstanding");
               err_count++;
            end else begin
               want = rsp_due_q.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_item.status));
               compare_field("read_value", want.read_value, rsp_item.read_value);
               compare_field("found_index", 32'(want.found_index),
                             32'(rsp_item.found_index));
               compare_field("entry_count", 32'(want.entry_count),
                             32'(rsp_item.entry_count));
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            rsp_due_q.insert(rsp_due_q.size(), apply_list_op(req_item));
         end
      end
      pending <= rsp_due_q.size();
   end

endmodule

// ===== verif/compacting_value_list_engine_tb.sv =====
module compacting_value_list_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cvle_pkg::*;

   localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
   localparam int         RANDOM_ITEMS    = 900;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   cvle_req_type req_item;
   logic         rsp_strobe;
   cvle_rsp_type rsp_item;
   int           err_count;
   int           pending;
   int           items_sent;
   bit           no_gaps;
   bit           mid_pause_done;

   compacting_value_list_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   cvle_list_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .err_count  (err_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // small values mostly, so find and remove hit stored entries often
   function automatic logic signed [31:0] pick_operand();
      if ($urandom_range(0, 3) != 0) return $signed($urandom_range(0, 6)) - 3;
      return $urandom;
   endfunction

   // returns in the time step of the edge that took the item
   task automatic issue_item(input logic [2:0] act, input logic signed [31:0] opd,
                             input logic [5:0] pos);
      int           gap;
      cvle_req_type it;
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      it.action   = act;
      it.operand  = opd;
      it.position = pos;
      repeat (gap) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int         ep_len;
      int         pick;
      logic [2:0] act;
      logic [5:0] pos;
      start          = 1'b0;
      req_item       = '0;
      reset          = 1'b1;
      items_sent     = 0;
      no_gaps        = 1'b0;
      mid_pause_done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty list corners
      issue_item(ACT_GET, 0, 6'd0);
      issue_item(ACT_FIND, 0, 6'd0);
      issue_item(ACT_REMOVE, 0, 6'd0);
      issue_item(ACT_ADD, 5, 6'd0);
      for (int a = int'(ACT_SPARE_FIRST); a <= int'(ACT_SPARE_LAST); a++) begin
         issue_item(3'(a), $urandom, 6'($urandom));
      end
      // operand extremes, then wrap on add and compaction on remove
      issue_item(ACT_PUSH, 32'h7fff_ffff, 6'd0);
      issue_item(ACT_PUSH, 32'h8000_0000, 6'd0);
      issue_item(ACT_PUSH, 0, 6'd0);
      issue_item(ACT_PUSH, -1, 6'd0);
      issue_item(ACT_GET, 0, 6'd0);
      issue_item(ACT_GET, 0, 6'd3);
      issue_item(ACT_GET, 0, 6'd4);
      issue_item(ACT_GET, 0, 6'd63);
      issue_item(ACT_FIND, -1, 6'd0);
      issue_item(ACT_ADD, 1, 6'd0);
      issue_item(ACT_FIND, 0, 6'd0);
      issue_item(ACT_REMOVE, 32'h8000_0001, 6'd0);
      issue_item(ACT_GET, 0, 6'd1);
      issue_item(ACT_REMOVE, 32'h0001_2345, 6'd0);
      issue_item(ACT_ADD, -1, 6'd0);
      issue_item(ACT_PUSH, 32'h7fff_ffff, 6'd63);
      wait_for_results();

      // run into the full list early
      repeat (66) issue_item(ACT_PUSH, pick_operand(), 6'($urandom));

      while (items_sent < RANDOM_ITEMS) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            repeat (66) issue_item(ACT_PUSH, pick_operand(), 6'($urandom));
         end else if (pick == 1) begin
            repeat (25) issue_item(ACT_REMOVE, pick_operand(), 6'($urandom));
         end else begin
            ep_len = $urandom_range(10, 30);
            repeat (ep_len) begin
               pick = $urandom_range(0, 99);
               pos  = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 15)) : 6'($urandom);
               if (pick < 30) act = ACT_PUSH;
               else if (pick < 40) act = ACT_ADD;
               else if (pick < 58) act = ACT_GET;
               else if (pick < 74) act = ACT_FIND;
               else if (pick < 94) act = ACT_REMOVE;
               else act = 3'($urandom_range(int'(ACT_SPARE_FIRST), int'(ACT_SPARE_LAST)));
               issue_item(act, pick_operand(), pos);
            end
         end
         if (!mid_pause_done && items_sent >= RANDOM_ITEMS / 2) begin
            wait_for_results();
            mid_pause_done = 1'b1;
         end
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cvle_pkg.sv
rtl/cvle_ram.sv
rtl/cvle_alu.sv
rtl/compacting_value_list_engine.sv
verif/cvle_list_checker.sv
verif/compacting_value_list_engine_tb.sv
